@@ hw/rtl/bmpg_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpg_pkg
// Shared types and constants for the brush mask pixel generator.
// ----------------------------------------------------------------------------
package bmpg_pkg;

   localparam int TABLE_DEPTH = 16384;
   localparam int OVERSAMPLE  = 4;
   localparam int TA_W        = $clog2(TABLE_DEPTH);

   localparam int MA_W  = 19;   // multiplier operand a, signed
   localparam int MB_W  = 47;   // multiplier operand b, signed
   localparam int ACC_W = 64;
   localparam int TW    = 47;   // rotated coordinate
   localparam int AW    = 30;   // clamped magnitude
   localparam int SQ_W  = 62;
   localparam int D_W   = 31;
   localparam int OS_W  = $clog2(OVERSAMPLE) + 1;
   localparam int IX_W  = D_W + OS_W + 1;

   localparam logic [AW-1:0] COORD_LIMIT = AW'(1) << 29;

   typedef enum logic [2:0] {
      REG_SHAPE    = 3'd0,
      REG_SPIKES   = 3'd1,
      REG_ANG_COS  = 3'd2,
      REG_ANG_SIN  = 3'd3,
      REG_STEP_COS = 3'd4,
      REG_STEP_SIN = 3'd5,
      REG_STRETCH  = 3'd6,
      REG_RADIUS   = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      SHAPE_CIRCLE  = 2'd0,
      SHAPE_SQUARE  = 2'd1,
      SHAPE_DIAMOND = 2'd2,
      SHAPE_NONE    = 2'd3
   } shape_type;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_ROT   = 11'b00000000010,
      ST_FOLD  = 11'b00000000100,
      ST_CLAMP = 11'b00000001000,
      ST_STR   = 11'b00000010000,
      ST_SHAPE = 11'b00000100000,
      ST_SQR   = 11'b00001000000,
      ST_SQRT  = 11'b00010000000,
      ST_IDX   = 11'b00100000000,
      ST_READ  = 11'b01000000000,
      ST_DONE  = 11'b10000000000
   } state_type;

endpackage

@@ hw/rtl/brush_mask_pixel_generator_core.sv @@
// ----------------------------------------------------------------------------
// brush_mask_pixel_generator_core
// Brush mask coverage per pixel: rotate, spike fold, stretch, distance, and
// falloff table lookup; the multiplies share one multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Input channel (req_*): one transaction is either a falloff table write
// (req_mode 0, no result) or a pixel (req_mode 1, one rsp_coverage result).
// Table writes leave the sequencer idle. A pixel runs through a sequencer
// around one shared 19x47 multiplier: rotation, then spike fold steps when
// the spike count is above 2 (up to spike_count/2+1 steps, with a test in
// each step that can end folding early), clamp, stretch, shape select,
// then for the circle squaring and a bit-serial square root, then an index
// check, a table read when distance and index are in range (else a zero
// result), and hand over.
// req_stall is high for the whole of a pixel transaction.
// The result sits in an output register; a new transaction is accepted
// while it waits, and the sequencer only holds in its last state when a
// second result is ready before the first has been taken (rsp_stall).
// Reset returns the control state and registers to their defaults; the
// falloff table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module brush_mask_pixel_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic signed [11:0] req_pixel_x,
   input  logic signed [11:0] req_pixel_y,
   input  logic [13:0] req_table_index,
   input  logic [7:0]  req_table_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_coverage,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bmpg_pkg::*;

   // configuration
   logic [1:0]         shape_ff;
   logic [4:0]         spikes_ff;
   logic signed [15:0] ang_cos_ff, ang_sin_ff, step_cos_ff, step_sin_ff;
   logic [17:0]        stretch_ff;
   logic [15:0]        radius_ff;

   state_type state_ff, state_in;
   logic [1:0]  ph_ff, ph_in;
   logic [4:0]  k_ff, k_in;
   logic signed [11:0] x_ff, y_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [TW-1:0] tx_ff, tx_in, ty_ff, ty_in, nx_ff, nx_in;
   logic [AW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [SQ_W-1:0] sv_ff, sv_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [D_W-1:0] d_ff, d_in;
   logic [7:0]  res_ff, res_in;
   logic [7:0]  mem_rd_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_cov_ff, rsp_cov_in;

   logic [7:0] table_mem [TABLE_DEPTH];

   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [MA_W+MB_W-1:0] mul_p;
   logic signed [ACC_W-1:0] prod;
   logic signed [ACC_W-1:0] sum, diff;
   logic [TW-1:0] mag_tx, mag_ty;
   logic [ACC_W-1:0] str_v;
   logic [SQ_W-1:0] sq_t;
   logic [4:0]  steps;
   logic [27:0] lim;
   logic [IX_W-1:0] idx;
   logic req_acc, cfg_wr, out_free;

   assign req_acc   = req_valid && !req_stall;
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_coverage = rsp_cov_ff;
   assign pready    = 1'b1;

   assign steps = {1'b0, spikes_ff[4:1]} + 5'd1;
   assign lim   = {17'({1'b0, radius_ff} + 17'd16), 11'd0};
   assign idx   = (IX_W'(d_ff) * IX_W'(OVERSAMPLE) + IX_W'(2**14)) >> 15;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ROT: begin
            mul_a = (ph_ff == 2'd0 || ph_ff == 2'd3) ? MA_W'(ang_cos_ff) : MA_W'(ang_sin_ff);
            mul_b = (ph_ff == 2'd0 || ph_ff == 2'd2) ? MB_W'(x_ff) : MB_W'(y_ff);
         end
         ST_FOLD: begin
            mul_a = (ph_ff == 2'd0 || ph_ff == 2'd3) ? MA_W'(step_cos_ff)
                                                     : MA_W'(step_sin_ff);
            mul_b = (ph_ff == 2'd0 || ph_ff == 2'd2) ? MB_W'(tx_ff) : MB_W'(ty_ff);
         end
         ST_STR: begin
            mul_a = $signed({1'b0, stretch_ff});
            mul_b = $signed(MB_W'(ay_ff));
         end
         ST_SQR: begin
            unique case (ph_ff)
               2'd0: mul_a = $signed(MA_W'(ax_ff[14:0]));
               2'd1: mul_a = $signed(MA_W'(ax_ff[29:15]));
               2'd2: mul_a = $signed(MA_W'(ay_ff[14:0]));
               default: mul_a = $signed(MA_W'(ay_ff[29:15]));
            endcase
            mul_b = ph_ff[1] ? $signed(MB_W'(ay_ff)) : $signed(MB_W'(ax_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign prod  = ACC_W'(mul_p);
   assign sum   = acc_ff + prod;
   assign diff  = acc_ff - prod;
   assign mag_tx = tx_ff[TW-1] ? TW'(-tx_ff) : TW'(tx_ff);
   assign mag_ty = ty_ff[TW-1] ? TW'(-ty_ff) : TW'(ty_ff);
   assign str_v  = ACC_W'((prod + ACC_W'(128)) >>> 8);
   assign sq_t   = sr_ff + sb_ff;

   // sequencer and datapath
   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      nx_in    = nx_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      sv_in    = sv_ff;
      sr_in    = sr_ff;
      sb_in    = sb_ff;
      d_in     = d_ff;
      res_in   = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cov_in   = rsp_cov_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_mode) begin
               state_in = ST_ROT;
               ph_in    = 2'd0;
            end
         end
         ST_ROT: begin
            ph_in = ph_ff + 2'd1;
            unique case (ph_ff)
               2'd0: acc_in = prod;
               2'd1: tx_in  = TW'(diff);
               2'd2: acc_in = prod;
               default: begin
                  ty_in = TW'(sum[ACC_W-1] ? -sum : sum);
                  k_in  = '0;
                  state_in = (spikes_ff > 5'd2) ? ST_FOLD : ST_CLAMP;
               end
            endcase
         end
         ST_FOLD: begin
            ph_in = ph_ff + 2'd1;
            unique case (ph_ff)
               2'd0: acc_in = prod;
               2'd1: begin
                  nx_in = TW'((diff + ACC_W'(2**14)) >>> 15);
                  if (!(diff > (ACC_W'(tx_ff) <<< 15))) begin
                     state_in = ST_CLAMP;
                  end
               end
               2'd2: acc_in = prod;
               default: begin
                  ty_in = TW'((sum + ACC_W'(2**14)) >>> 15);
                  tx_in = nx_ff;
                  k_in  = k_ff + 5'd1;
                  if (k_ff + 5'd1 == steps) begin
                     state_in = ST_CLAMP;
                  end
               end
            endcase
         end
         ST_CLAMP: begin
            ax_in = (mag_tx > TW'(COORD_LIMIT)) ? COORD_LIMIT : mag_tx[AW-1:0];
            ay_in = (mag_ty > TW'(COORD_LIMIT)) ? COORD_LIMIT : mag_ty[AW-1:0];
            state_in = ST_STR;
         end
         ST_STR: begin
            ay_in = (str_v > ACC_W'(COORD_LIMIT)) ? COORD_LIMIT : str_v[AW-1:0];
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            ph_in = 2'd0;
            unique case (shape_type'(shape_ff))
               SHAPE_CIRCLE: state_in = ST_SQR;
               SHAPE_SQUARE: begin
                  d_in = D_W'((ax_ff > ay_ff) ? ax_ff : ay_ff);
                  state_in = ST_IDX;
               end
               SHAPE_DIAMOND: begin
                  d_in = D_W'(ax_ff) + D_W'(ay_ff);
                  state_in = ST_IDX;
               end
               default: begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SQR: begin
            ph_in = ph_ff + 2'd1;
            unique case (ph_ff)
               2'd0: acc_in = prod;
               2'd1: acc_in = acc_ff + (prod <<< 15);
               2'd2: acc_in = sum;
               default: begin
                  sv_in = SQ_W'(acc_ff + (prod <<< 15));
                  sr_in = '0;
                  sb_in = SQ_W'(1) << 60;
                  state_in = ST_SQRT;
               end
            endcase
         end
         ST_SQRT: begin
            if (sv_ff >= sq_t) begin
               sv_in = sv_ff - sq_t;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in = sb_ff >> 2;
            if (sb_ff[0]) begin
               d_in = (sv_ff >= sq_t) ? D_W'((sr_ff >> 1) + sb_ff) : D_W'(sr_ff >> 1);
               state_in = ST_IDX;
            end
         end
         ST_IDX: begin
            if (d_ff < D_W'(lim) && idx < IX_W'(TABLE_DEPTH)) begin
               state_in = ST_READ;
            end else begin
               res_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            res_in   = mem_rd_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cov_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff     <= acc_in;
      tx_ff      <= tx_in;
      ty_ff      <= ty_in;
      nx_ff      <= nx_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      sv_ff      <= sv_in;
      sr_ff      <= sr_in;
      sb_ff      <= sb_in;
      d_ff       <= d_in;
      res_ff     <= res_in;
      rsp_cov_ff <= rsp_cov_in;
      if (req_acc) begin
         x_ff <= req_pixel_x;
         y_ff <= req_pixel_y;
      end
   end

   // falloff table
   always_ff @(posedge clock) begin
      if (req_acc && !req_mode && 32'(req_table_index) < TABLE_DEPTH) begin
         table_mem[TA_W'(req_table_index)] <= req_table_value;
      end
      if (state_ff == ST_IDX) begin
         mem_rd_ff <= table_mem[idx[TA_W-1:0]];
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff    <= 2'd0;
         spikes_ff   <= 5'd2;
         ang_cos_ff  <= 16'sd32767;
         ang_sin_ff  <= '0;
         step_cos_ff <= 16'sh8000;
         step_sin_ff <= '0;
         stretch_ff  <= 18'd256;
         radius_ff   <= 16'd80;
      end else if (cfg_wr) begin
         unique case (reg_idx_type'(paddr[4:2]))
            REG_SHAPE:    shape_ff    <= pwdata[1:0];
            REG_SPIKES:   spikes_ff   <= pwdata[4:0];
            REG_ANG_COS:  ang_cos_ff  <= pwdata[15:0];
            REG_ANG_SIN:  ang_sin_ff  <= pwdata[15:0];
            REG_STEP_COS: step_cos_ff <= pwdata[15:0];
            REG_STEP_SIN: step_sin_ff <= pwdata[15:0];
            REG_STRETCH:  stretch_ff  <= pwdata[17:0];
            REG_RADIUS:   radius_ff   <= pwdata[15:0];
            default:      shape_ff    <= shape_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx_type'(paddr[4:2]))
         REG_SHAPE:    prdata = 32'(shape_ff);
         REG_SPIKES:   prdata = 32'(spikes_ff);
         REG_ANG_COS:  prdata = {16'd0, ang_cos_ff};
         REG_ANG_SIN:  prdata = {16'd0, ang_sin_ff};
         REG_STEP_COS: prdata = {16'd0, step_cos_ff};
         REG_STEP_SIN: prdata = {16'd0, step_sin_ff};
         REG_STRETCH:  prdata = 32'(stretch_ff);
         REG_RADIUS:   prdata = 32'(radius_ff);
         default:      prdata = '0;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final state");
   a_pixel_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_mode) |=> (state_ff == ST_ROT && ph_ff == 2'd0))
      else $error("pixel transaction did not start rotation");
   a_fold_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> (k_ff < steps))
      else $error("fold step count exceeded");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("result lost while output stalled");
`endif

endmodule

@@ tb/brush_mask_pixel_generator_core_tb.sv @@
// ----------------------------------------------------------------------------
// brush_mask_pixel_generator_core_tb
// Self-checking bench: loads the falloff table and sends pixels over the
// request channel in bursts while the result side stalls on its own pattern.
// Each accepted pixel is predicted by a bit-accurate local model (rotate,
// spike fold, stretch, distance, table lookup) and checked in order against
// the coverage results. Register settings change between phases, while idle.
// ----------------------------------------------------------------------------
module brush_mask_pixel_generator_core_tb;
   import bmpg_pkg::*;

   typedef struct {
      bit          hold;
      logic        mode;
      logic [11:0] px;
      logic [11:0] py;
      logic [13:0] tidx;
      logic [7:0]  tval;
   } req_item_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic signed [11:0] req_pixel_x = '0;
   logic signed [11:0] req_pixel_y = '0;
   logic [13:0] req_table_index = '0;
   logic [7:0]  req_table_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_coverage;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   brush_mask_pixel_generator_core u_top (.*);

   // register shadows
   logic [1:0]         sh_shape;
   logic [4:0]         sh_spikes;
   logic signed [15:0] sh_acos, sh_asin, sh_scos, sh_ssin;
   logic [17:0]        sh_stretch;
   logic [15:0]        sh_radius;

   req_item_t   pending_q[$];
   logic [7:0]  coverage_q[$];
   logic [7:0]  falloff_shadow [TABLE_DEPTH];
   bit          loaded [TABLE_DEPTH];
   int          errors = 0;
   int          drive_count = 0, accept_count = 0;
   int          pixels_done = 0, writes_done = 0;
   int          burst_left = 0, gap_left = 0;
   int          stall_mode = 0, stall_timer = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // falloff index for a pixel under the current settings; hit is low when
   // the pixel is outside, the index is past the table, or the shape is unused
   function automatic void falloff_index(input longint x, input longint y,
                                         output bit hit, output int idx);
      longint c, s, cs, ss, tx, ty, ntx, nty, ax, ay, lim, d, lmt;
      longint unsigned sq, ix;
      bit in_brush;
      int steps;
      c = longint'(sh_acos);
      s = longint'(sh_asin);
      cs = longint'(sh_scos);
      ss = longint'(sh_ssin);
      lmt = 64'sd1 << 29;
      tx = c * x - s * y;
      ty = s * x + c * y;
      if (ty < 0) ty = -ty;
      if (sh_spikes > 2) begin
         steps = sh_spikes / 2 + 1;
         for (int k = 0; k < steps; k++) begin
            if (!(tx * cs - ty * ss > tx * 32768)) break;
            ntx = (cs * tx - ss * ty + 16384) >>> 15;
            nty = (ss * tx + cs * ty + 16384) >>> 15;
            tx = ntx;
            ty = nty;
         end
      end
      ax = (tx < 0) ? -tx : tx;
      if (ax > lmt) ax = lmt;
      ay = (ty < 0) ? -ty : ty;
      if (ay > lmt) ay = lmt;
      ay = (ay * longint'(sh_stretch) + 128) >>> 8;
      if (ay > lmt) ay = lmt;
      lim = (longint'(sh_radius) + 16) << 11;
      hit = 1'b0;
      idx = 0;
      d = 0;
      in_brush = 1'b0;
      case (shape_type'(sh_shape))
         SHAPE_CIRCLE: begin
            sq = longint'(ax * ax + ay * ay);
            in_brush = sq < longint'(lim * lim);
            d = longint'(floor_sqrt(sq));
         end
         SHAPE_SQUARE: begin
            d = (ax > ay) ? ax : ay;
            in_brush = d < lim;
         end
         SHAPE_DIAMOND: begin
            d = ax + ay;
            in_brush = d < lim;
         end
         default: in_brush = 1'b0;
      endcase
      if (in_brush) begin
         ix = (d * OVERSAMPLE + 16384) >> 15;
         if (ix < TABLE_DEPTH) begin
            hit = 1'b1;
            idx = int'(ix);
         end
      end
   endfunction

   task automatic csr_write(input reg_idx_type r, input logic [31:0] v);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 5'(r) << 2;
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic signed [15:0] to_q15(input real v);
      real t;
      t = v * 32767.0;
      return 16'($rtoi(t < 0.0 ? t - 0.5 : t + 0.5));
   endfunction

   task automatic set_regs(input shape_type sh, input int spk, input int ac,
                           input int as_, input int sc, input int ssn,
                           input int str, input int rad);
      sh_shape = sh;
      sh_spikes = 5'(spk);
      sh_acos = 16'(ac);
      sh_asin = 16'(as_);
      sh_scos = 16'(sc);
      sh_ssin = 16'(ssn);
      sh_stretch = 18'(str);
      sh_radius = 16'(rad);
      csr_write(REG_SHAPE, 32'(sh_shape));
      csr_write(REG_SPIKES, 32'(sh_spikes));
      csr_write(REG_ANG_COS, 32'(sh_acos));
      csr_write(REG_ANG_SIN, 32'(sh_asin));
      csr_write(REG_STEP_COS, 32'(sh_scos));
      csr_write(REG_STEP_SIN, 32'(sh_ssin));
      csr_write(REG_STRETCH, 32'(sh_stretch));
      csr_write(REG_RADIUS, 32'(sh_radius));
   endtask

   task automatic set_shape(input shape_type sh, input int spk, input real deg,
                            input int str, input int rad);
      real a, st;
      a = deg * 3.14159265358979 / 180.0;
      st = -2.0 * 3.14159265358979 / spk;
      set_regs(sh, spk, to_q15($cos(a)), to_q15($sin(a)), to_q15($cos(st)),
               to_q15($sin(st)), str, rad);
   endtask

   task automatic push_write(input int i, input int v);
      req_item_t it;
      it = '{hold: 1'b0, mode: 1'b0, px: '0, py: '0, tidx: 14'(i), tval: 8'(v)};
      it.px = 12'($urandom);
      it.py = 12'($urandom);
      pending_q.push_back(it);
      loaded[i] = 1'b1;
   endtask

   // table entries the pixel will read are loaded first
   task automatic push_pixel(input int x, input int y);
      req_item_t it;
      bit hit;
      int idx;
      falloff_index(x, y, hit, idx);
      if (hit && !loaded[idx]) push_write(idx, $urandom_range(255));
      it = '{hold: 1'b0, mode: 1'b1, px: 12'(x), py: 12'(y), tidx: '0, tval: '0};
      it.tidx = 14'($urandom);
      it.tval = 8'($urandom);
      pending_q.push_back(it);
   endtask

   task automatic push_hold();
      req_item_t it;
      it = '{hold: 1'b1, mode: 1'b0, px: '0, py: '0, tidx: '0, tval: '0};
      pending_q.push_back(it);
   endtask

   task automatic random_items(input int n);
      int span, x, y;
      span = (int'(sh_radius) / 16) * 2 + 4;
      if (span > 2047) span = 2047;
      for (int k = 0; k < n; k++) begin
         if (k == n / 2) push_hold();
         if ($urandom_range(9) < 2) begin
            push_write($urandom_range(TABLE_DEPTH - 1), $urandom_range(255));
         end else if ($urandom_range(9) < 6) begin
            x = $urandom_range(2 * span) - span;
            y = $urandom_range(2 * span) - span;
            push_pixel(x, y);
         end else begin
            push_pixel(int'($signed(12'($urandom))), int'($signed(12'($urandom))));
         end
      end
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req_valid || coverage_q.size() != 0)
         @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      req_item_t it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || accept_count == drive_count) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0 &&
                      !(pending_q[0].hold && coverage_q.size() != 0)) begin
            while (pending_q.size() != 0 && pending_q[0].hold) void'(pending_q.pop_front());
            if (pending_q.size() != 0) begin
               it = pending_q.pop_front();
               req_valid <= 1'b1;
               req_mode <= it.mode;
               req_pixel_x <= it.px;
               req_pixel_y <= it.py;
               req_table_index <= it.tidx;
               req_table_value <= it.tval;
               drive_count <= drive_count + 1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(30, 1);
                  gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall pattern: none, sparse, heavy, long runs
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode <= $urandom_range(3);
         stall_timer <= $urandom_range(400, 50);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(9) < 2);
         2: rsp_stall <= ($urandom_range(9) < 7);
         default: rsp_stall <= (stall_timer % 64) < 40;
      endcase
   end

   // prediction on acceptance, check on result
   always @(posedge clock) begin
      bit hit;
      int idx;
      logic [7:0] want;
      if (!reset && req_valid && !req_stall) begin
         accept_count <= accept_count + 1;
         if (req_mode == 1'b0) begin
            falloff_shadow[req_table_index] = req_table_value;
            writes_done++;
         end else begin
            falloff_index(int'(req_pixel_x), int'(req_pixel_y), hit, idx);
            coverage_q.push_back(hit ? falloff_shadow[idx] : 8'd0);
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (coverage_q.size() == 0) begin
            $display("%0t: unexpected transaction, coverage %0d", $time, rsp_coverage);
            errors++;
         end else begin
            want = coverage_q.pop_front();
            pixels_done++;
            if (rsp_coverage !== want) begin
               $display("%0t: coverage mismatch, expected %0d actual %0d",
                        $time, want, rsp_coverage);
               errors++;
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("brush_mask_pixel_generator_core_tb: FAIL");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (4) @(negedge clock);

      // directed
      set_regs(SHAPE_CIRCLE, 2, 32767, 0, -32768, 0, 256, 80);
      push_write(0, 255);
      push_write(TABLE_DEPTH - 1, 0);
      push_write(1, 0);
      push_write(TABLE_DEPTH - 1, 255);
      push_write(2, 128);
      push_pixel(0, 0);
      push_pixel(1, 0);
      push_pixel(0, -1);
      push_pixel(4, 3);
      push_pixel(5, 0);
      push_pixel(-5, 0);
      push_pixel(6, 0);
      push_pixel(-2048, -2048);
      push_pixel(2047, 2047);
      push_pixel(-2048, 2047);
      push_pixel(2047, -2048);
      push_pixel(0, 2047);
      push_hold();
      push_pixel(3, -4);
      random_items(140);
      drain();

      set_shape(SHAPE_SQUARE, 5, 30.0, 512, 200);
      random_items(150);
      drain();
      set_shape(SHAPE_DIAMOND, 20, -100.0, 256000, 65535);
      random_items(150);
      drain();
      set_shape(SHAPE_NONE, 8, 10.0, 256, 160);
      random_items(60);
      drain();
      set_regs(SHAPE_CIRCLE, 7, -32768, -32768, 32767, 32767, 1000, 1);
      random_items(150);
      drain();
      set_shape(SHAPE_CIRCLE, 3, 45.0, 300, 16000);
      random_items(150);
      drain();
      set_regs(SHAPE_SQUARE, 12, 20000, -25000, $urandom_range(65535),
               $urandom_range(65535), 256, 65535);
      random_items(150);
      drain();
      set_shape(SHAPE_CIRCLE, 4, 75.0, 700, 500);
      random_items(150);
      drain();
      set_regs(SHAPE_DIAMOND, 31, -32768, 32767, -32768, -32768, 0, 300);
      random_items(100);
      drain();

      $display("Checked %0d pixel coverages and %0d table loads", pixels_done, writes_done);
      $display("over nine register settings: all shapes, spike folds and extremes");
      if (errors == 0) begin
         $display("brush_mask_pixel_generator_core_tb: PASS");
      end else begin
         $display("brush_mask_pixel_generator_core_tb: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/bmpg_pkg.sv
hw/rtl/brush_mask_pixel_generator_core.sv
tb/brush_mask_pixel_generator_core_tb.sv
